@@ sv/bpa_pkg.sv @@
// Shared constants, microcode types and control store for the bitmap page allocator.
package bpa_pkg;

  localparam int MAX_PAGES = 4096;
  localparam int WORD_BITS = 32;
  localparam int NUM_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW   = $clog2(NUM_WORDS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int PTR_W     = WORD_AW + 1;
  localparam int IDX_W     = 12;
  localparam int CNT_W     = 13;
  localparam int PC_W      = 4;

  localparam logic [CNT_W-1:0] MAX_PAGES_C = CNT_W'(MAX_PAGES);

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_FREE    = 2'd1,
    REQ_RESERVE = 2'd2,
    REQ_BAD     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OOM   = 2'd1,
    ST_RANGE = 2'd2,
    ST_SAME  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BR_NEXT     = 2'd0,
    BR_GOTO     = 2'd1,
    BR_IF       = 2'd2,
    BR_DISPATCH = 2'd3
  } br_t;

  typedef enum logic [2:0] {
    C_NO_START  = 3'd0,
    C_SCAN_DONE = 3'd1,
    C_MORE_FULL = 3'd2,
    C_FULL      = 3'd3,
    C_RANGE     = 3'd4,
    C_SAME      = 3'd5
  } cond_t;

  typedef enum logic [1:0] {
    RD_NONE      = 2'd0,
    RD_PTR       = 2'd1,
    RD_SCAN_STEP = 2'd2,
    RD_IDX       = 2'd3
  } rd_t;

  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_ALLOC = 2'd1,
    WR_PAGE  = 2'd2
  } wr_t;

  typedef enum logic [1:0] {
    CNT_NONE = 2'd0,
    CNT_INC  = 2'd1,
    CNT_WANT = 2'd2
  } cnt_t;

  typedef enum logic [1:0] {
    G_SCAN = 2'd0,
    G_IDX  = 2'd1,
    G_ZERO = 2'd2
  } gsel_t;

  // step addresses
  localparam logic [PC_W-1:0] S_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] S_DISPATCH = 4'd1;
  localparam logic [PC_W-1:0] S_SCAN0    = 4'd2;
  localparam logic [PC_W-1:0] S_SCAN     = 4'd3;
  localparam logic [PC_W-1:0] S_SCAN_END = 4'd4;
  localparam logic [PC_W-1:0] S_GRANT    = 4'd5;
  localparam logic [PC_W-1:0] S_FR_CHK   = 4'd6;
  localparam logic [PC_W-1:0] S_FR_TEST  = 4'd7;
  localparam logic [PC_W-1:0] S_FR_DO    = 4'd8;
  localparam logic [PC_W-1:0] S_SAME     = 4'd9;
  localparam logic [PC_W-1:0] S_RANGE    = 4'd10;
  localparam logic [PC_W-1:0] S_OOM      = 4'd11;

  typedef struct packed {
    br_t              br;
    cond_t            cond;
    logic [PC_W-1:0]  target;
    logic             load_req;
    logic             clr_ptr;
    rd_t              rd;
    wr_t              wr;
    cnt_t             cnt;
    logic             emit;
    status_t          status;
    gsel_t            gsel;
  } cw_t;

  typedef struct packed {
    logic scan_done;
    logic more_full;
    logic full;
    logic range;
    logic same;
    req_t req;
  } flags_t;

  localparam cw_t CW_NOP = '{
    br: BR_NEXT, cond: C_NO_START, target: S_IDLE, load_req: 1'b0, clr_ptr: 1'b0,
    rd: RD_NONE, wr: WR_NONE, cnt: CNT_NONE, emit: 1'b0, status: ST_OK, gsel: G_IDX
  };

  function automatic cw_t ucode(input logic [PC_W-1:0] pc);
    cw_t cw;
    cw = CW_NOP;
    unique case (pc)
      S_IDLE: begin
        cw.br = BR_IF; cw.cond = C_NO_START; cw.target = S_IDLE; cw.load_req = 1'b1;
      end
      S_DISPATCH: begin
        cw.br = BR_DISPATCH; cw.clr_ptr = 1'b1;
      end
      S_SCAN0: begin
        cw.br = BR_IF; cw.cond = C_SCAN_DONE; cw.target = S_OOM; cw.rd = RD_PTR;
      end
      S_SCAN: begin
        // one word per cycle while words stay full
        cw.br = BR_IF; cw.cond = C_MORE_FULL; cw.target = S_SCAN; cw.rd = RD_SCAN_STEP;
      end
      S_SCAN_END: begin
        cw.br = BR_IF; cw.cond = C_FULL; cw.target = S_OOM;
      end
      S_GRANT: begin
        cw.br = BR_GOTO; cw.target = S_IDLE; cw.wr = WR_ALLOC; cw.cnt = CNT_INC;
        cw.emit = 1'b1; cw.status = ST_OK; cw.gsel = G_SCAN;
      end
      S_FR_CHK: begin
        cw.br = BR_IF; cw.cond = C_RANGE; cw.target = S_RANGE; cw.rd = RD_IDX;
      end
      S_FR_TEST: begin
        cw.br = BR_IF; cw.cond = C_SAME; cw.target = S_SAME;
      end
      S_FR_DO: begin
        cw.br = BR_GOTO; cw.target = S_IDLE; cw.wr = WR_PAGE; cw.cnt = CNT_WANT;
        cw.emit = 1'b1; cw.status = ST_OK; cw.gsel = G_IDX;
      end
      S_SAME: begin
        cw.br = BR_GOTO; cw.target = S_IDLE; cw.emit = 1'b1; cw.status = ST_SAME;
        cw.gsel = G_IDX;
      end
      S_RANGE: begin
        cw.br = BR_GOTO; cw.target = S_IDLE; cw.emit = 1'b1; cw.status = ST_RANGE;
        cw.gsel = G_IDX;
      end
      S_OOM: begin
        cw.br = BR_GOTO; cw.target = S_IDLE; cw.emit = 1'b1; cw.status = ST_OOM;
        cw.gsel = G_ZERO;
      end
      default: begin
        cw.br = BR_GOTO; cw.target = S_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

@@ sv/bitmap_page_allocator.sv @@
// Bitmap page allocator top level: first-fit page grant, free and reserve over a used-bit map.
// A request is taken when start is high and busy is low; its one result word appears on the
// out_ ports for a single cycle with out_valid high and cannot be held off by the receiver.
// A microcoded step counter runs each request. Free and reserve pass through dispatch, a range
// check that reads the page's bitmap word, a same-state test, then the update or an error result;
// an unknown request goes from dispatch straight to the range error. Allocate reads the bitmap
// memory one 32-page word per cycle through its single read port, stepping past full words
// until a free page turns up, and reports out of memory when all whole words are full or there
// are none. busy stays high until the cycle the result is shown; the next request may start
// then. Writing the managed page count marks every page used and must only happen while busy
// is low.
module bitmap_page_allocator import bpa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_req_type,
  input  logic [IDX_W-1:0]  in_page_index,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_wdata,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [IDX_W-1:0]  out_granted_page,
  output logic [CNT_W-1:0]  out_used_count,
  output logic [CNT_W-1:0]  out_free_count
);

  cw_t    cw;
  flags_t flags;

  bpa_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .flags (flags),
    .cw    (cw),
    .busy  (busy)
  );

  bpa_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cw               (cw),
    .start            (start),
    .in_req_type      (in_req_type),
    .in_page_index    (in_page_index),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .flags            (flags),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_granted_page (out_granted_page),
    .out_used_count   (out_used_count),
    .out_free_count   (out_free_count)
  );

endmodule

@@ sv/bpa_sequencer.sv @@
// Microcode sequencer: step counter, control store lookup and branch logic.
module bpa_sequencer import bpa_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  flags_t flags,
  output cw_t    cw,
  output logic   busy
);

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            cond_true;
  logic [PC_W-1:0] disp_target;

  assign cw   = ucode(pc_r);
  assign busy = (pc_r != S_IDLE);

  always_comb begin
    unique case (cw.cond)
      C_NO_START:  cond_true = !start;
      C_SCAN_DONE: cond_true = flags.scan_done;
      C_MORE_FULL: cond_true = flags.more_full;
      C_FULL:      cond_true = flags.full;
      C_RANGE:     cond_true = flags.range;
      C_SAME:      cond_true = flags.same;
      default:     cond_true = 1'b0;
    endcase
  end

  always_comb begin
    case (flags.req) inside
      REQ_ALLOC:             disp_target = S_SCAN0;
      REQ_FREE, REQ_RESERVE: disp_target = S_FR_CHK;
      default:               disp_target = S_RANGE;
    endcase
  end

  always_comb begin
    unique case (cw.br)
      BR_NEXT:     pc_nxt = pc_r + PC_W'(1);
      BR_GOTO:     pc_nxt = cw.target;
      BR_IF:       pc_nxt = cond_true ? cw.target : pc_r + PC_W'(1);
      BR_DISPATCH: pc_nxt = disp_target;
      default:     pc_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

@@ sv/bpa_datapath.sv @@
// Datapath: bitmap memory, scan pointer, used count and result registers.
module bpa_datapath import bpa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cw_t               cw,
  input  logic              start,
  input  logic [1:0]        in_req_type,
  input  logic [IDX_W-1:0]  in_page_index,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_wdata,
  output flags_t            flags,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [IDX_W-1:0]  out_granted_page,
  output logic [CNT_W-1:0]  out_used_count,
  output logic [CNT_W-1:0]  out_free_count
);

  logic [WORD_BITS-1:0] map_mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] vld_r;
  logic [WORD_BITS-1:0] rdata_r;
  logic                 rvld_r;

  logic [CNT_W-1:0]     total_r, used_r, used_nxt, cfg_sat;
  logic [PTR_W-1:0]     ptr_r, ptr_plus, words;
  logic [1:0]           req_r;
  logic [IDX_W-1:0]     idx_r;

  logic [WORD_BITS-1:0] eff, inv, lowbit, page_bit, wr_data;
  logic [BIT_W-1:0]     bitpos;
  logic                 want, rd_en, wr_en, scan_step;
  logic [WORD_AW-1:0]   rd_addr, wr_addr;

  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [IDX_W-1:0]     out_granted_r;
  logic [CNT_W-1:0]     out_used_r, out_free_r;

  // an entry not written since refill reads as all used
  assign eff      = rvld_r ? rdata_r : '1;
  assign inv      = ~eff;
  assign lowbit   = inv & (~inv + WORD_BITS'(1));
  assign page_bit = WORD_BITS'(1) << idx_r[BIT_W-1:0];
  assign want     = (req_r == REQ_RESERVE);
  assign words    = total_r[CNT_W-1:BIT_W];
  assign ptr_plus = ptr_r + PTR_W'(1);
  assign cfg_sat  = (cfg_wdata > MAX_PAGES_C) ? MAX_PAGES_C : cfg_wdata;

  always_comb begin
    bitpos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (inv[i]) bitpos = BIT_W'(i);
    end
  end

  always_comb begin
    flags.scan_done = (ptr_r >= words);
    flags.full      = (eff == '1);
    flags.more_full = (eff == '1) && (ptr_plus < words);
    flags.range     = ({1'b0, idx_r} >= total_r);
    flags.same      = (eff[idx_r[BIT_W-1:0]] == want);
    flags.req       = req_t'(req_r);
  end

  assign scan_step = (cw.rd == RD_SCAN_STEP) && flags.more_full;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr_r[WORD_AW-1:0];
    case (cw.rd)
      RD_PTR: begin
        rd_en = 1'b1;
      end
      RD_SCAN_STEP: begin
        rd_en   = scan_step;
        rd_addr = ptr_plus[WORD_AW-1:0];
      end
      RD_IDX: begin
        rd_en   = 1'b1;
        rd_addr = idx_r[IDX_W-1:BIT_W];
      end
      default: rd_en = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r[WORD_AW-1:0];
    wr_data = eff | lowbit;
    case (cw.wr)
      WR_ALLOC: wr_en = 1'b1;
      WR_PAGE: begin
        wr_en   = 1'b1;
        wr_addr = idx_r[IDX_W-1:BIT_W];
        wr_data = want ? (eff | page_bit) : (eff & ~page_bit);
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_comb begin
    case (cw.cnt)
      CNT_INC:  used_nxt = used_r + CNT_W'(1);
      CNT_WANT: used_nxt = want ? used_r + CNT_W'(1) : used_r - CNT_W'(1);
      default:  used_nxt = used_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) map_mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= map_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      rvld_r  <= 1'b0;
      total_r <= MAX_PAGES_C;
      used_r  <= MAX_PAGES_C;
      ptr_r   <= '0;
      req_r   <= '0;
      idx_r   <= '0;
    end else begin
      if (cfg_we) begin
        vld_r   <= '0;
        total_r <= cfg_sat;
        used_r  <= cfg_sat;
      end else begin
        if (wr_en) vld_r[wr_addr] <= 1'b1;
        used_r <= used_nxt;
      end
      if (rd_en) rvld_r <= vld_r[rd_addr];
      if (cw.clr_ptr) begin
        ptr_r <= '0;
      end else if (scan_step) begin
        ptr_r <= ptr_plus;
      end
      if (cw.load_req && start) begin
        req_r <= in_req_type;
        idx_r <= in_page_index;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cw.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.emit) begin
      out_status_r <= cw.status;
      out_used_r   <= used_nxt;
      out_free_r   <= total_r - used_nxt;
      case (cw.gsel)
        G_SCAN:  out_granted_r <= {ptr_r[WORD_AW-1:0], bitpos};
        G_ZERO:  out_granted_r <= '0;
        default: out_granted_r <= idx_r;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_granted_page = out_granted_r;
  assign out_used_count   = out_used_r;
  assign out_free_count   = out_free_r;

endmodule

@@ dv/bitmap_page_allocator_checker.sv @@
// Checker for the bitmap page allocator: mirrors the page map and compares every result word.
module bitmap_page_allocator_checker import bpa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  logic [1:0]       in_req_type,
  input  logic [IDX_W-1:0] in_page_index,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  logic             out_valid,
  input  logic [1:0]       out_status,
  input  logic [IDX_W-1:0] out_granted_page,
  input  logic [CNT_W-1:0] out_used_count,
  input  logic [CNT_W-1:0] out_free_count,
  output int               mismatches,
  output int               pending
);

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] page;
    logic [CNT_W-1:0] used;
    logic [CNT_W-1:0] avail;
  } page_result_t;

  logic [WORD_BITS-1:0] used_map [NUM_WORDS];
  logic [CNT_W-1:0]     in_use_cnt;
  logic [CNT_W-1:0]     managed_pages;
  page_result_t         grant_q [$];

  // every page marked used, count follows the managed total
  function automatic void refill_map();
    for (int w = 0; w < NUM_WORDS; w++) used_map[w] = '1;
    in_use_cnt = managed_pages;
  endfunction

  function automatic page_result_t serve_request(input req_t kind,
                                                 input logic [IDX_W-1:0] idx);
    page_result_t r;
    int           words;
    bit           found;
    logic         want;
    r.status = ST_OK;
    r.page   = idx;
    case (kind) inside
      REQ_ALLOC: begin
        // first fit over whole words only; a partial tail word is never granted
        r.page = '0;
        words  = managed_pages / WORD_BITS;
        found  = 1'b0;
        for (int w = 0; w < words && !found; w++) begin
          if (used_map[w] != '1) begin
            for (int b = 0; b < WORD_BITS && !found; b++) begin
              if (!used_map[w][b]) begin
                used_map[w][b] = 1'b1;
                r.page         = IDX_W'(w * WORD_BITS + b);
                in_use_cnt     = in_use_cnt + 1'b1;
                found          = 1'b1;
              end
            end
          end
        end
        if (!found) r.status = ST_OOM;
      end
      REQ_FREE, REQ_RESERVE: begin
        want = (kind == REQ_RESERVE);
        if (CNT_W'(idx) >= managed_pages) begin
          r.status = ST_RANGE;
        end else if (used_map[idx / WORD_BITS][idx % WORD_BITS] == want) begin
          r.status = ST_SAME;
        end else begin
          used_map[idx / WORD_BITS][idx % WORD_BITS] = want;
          in_use_cnt = want ? in_use_cnt + 1'b1 : in_use_cnt - 1'b1;
        end
      end
      default: r.status = ST_RANGE;
    endcase
    r.used  = in_use_cnt;
    r.avail = managed_pages - in_use_cnt;
    return r;
  endfunction

  always @(posedge clk) begin
    page_result_t exp_r;
    if (!rst_n) begin
      managed_pages = MAX_PAGES_C;
      refill_map();
      grant_q.delete();
    end else begin
      // results are checked before this edge's request word is predicted
      if (out_valid) begin
        if (grant_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected page result at %0t: status %0d page %0d used %0d free %0d",
                     $time, out_status, out_granted_page, out_used_count, out_free_count);
          mismatches++;
        end else begin
          exp_r = grant_q.pop_front();
          if (out_status != exp_r.status || out_granted_page != exp_r.page ||
              out_used_count != exp_r.used || out_free_count != exp_r.avail) begin
            if (mismatches < 10)
              $display("page result differs at %0t (exp/got): status %0d/%0d page %0d/%0d %s",
                       $time, exp_r.status, out_status, exp_r.page, out_granted_page,
                       $sformatf("used %0d/%0d free %0d/%0d", exp_r.used, out_used_count,
                                 exp_r.avail, out_free_count));
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        managed_pages = (cfg_wdata > MAX_PAGES_C) ? MAX_PAGES_C : cfg_wdata;
        refill_map();
      end
      if (start && !busy)
        grant_q.push_back(serve_request(req_t'(in_req_type), in_page_index));
    end
    pending = grant_q.size();
  end

endmodule

@@ dv/bitmap_page_allocator_test.sv @@
// Testbench top for the bitmap page allocator: clock, reset, request stimulus and verdict.
module bitmap_page_allocator_test;
  import bpa_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [1:0]       in_req_type;
  logic [IDX_W-1:0] in_page_index;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;
  logic             out_valid;
  logic [1:0]       out_status;
  logic [IDX_W-1:0] out_granted_page;
  logic [CNT_W-1:0] out_used_count;
  logic [CNT_W-1:0] out_free_count;
  int               mismatches;
  int               pending;

  int               gap_pct;
  logic [CNT_W-1:0] eff_total;

  bitmap_page_allocator u_dut (.*);
  bitmap_page_allocator_checker u_checker (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("bitmap_page_allocator: mismatch");
    $finish;
  end

  // random hold-off, then one request word held until the block takes it
  task automatic issue(input req_t kind, input logic [IDX_W-1:0] idx);
    if ($urandom_range(0, 99) < gap_pct) begin
      @(negedge clk);
      start = 1'b0;
      while ($urandom_range(0, 99) < gap_pct) @(negedge clk);
    end
    @(negedge clk);
    start         = 1'b1;
    in_req_type   = kind;
    in_page_index = idx;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_total(input logic [CNT_W-1:0] v);
    @(negedge clk);
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
    eff_total = (v > MAX_PAGES_C) ? MAX_PAGES_C : v;
  endtask

  // mostly in-range free/reserve/allocate traffic, some wild indices and bad opcodes
  task automatic random_item();
    int               pick;
    logic [IDX_W-1:0] idx;
    pick = $urandom_range(0, 99);
    idx  = (eff_total != 0) ? IDX_W'($urandom_range(0, eff_total - 1)) : IDX_W'($urandom);
    if (pick < 36)      issue(REQ_ALLOC, IDX_W'($urandom));
    else if (pick < 68) issue(REQ_FREE, idx);
    else if (pick < 84) issue(REQ_RESERVE, idx);
    else if (pick < 95) issue($urandom_range(0, 1) ? REQ_FREE : REQ_RESERVE, IDX_W'($urandom));
    else                issue(REQ_BAD, IDX_W'($urandom));
  endtask

  initial begin
    logic [CNT_W-1:0] fixed_totals [5];
    logic [CNT_W-1:0] v;
    fixed_totals  = '{13'd4096, 13'd64, 13'd8191, 13'd0, 13'd1000};
    rst_n         = 1'b0;
    start         = 1'b0;
    in_req_type   = REQ_ALLOC;
    in_page_index = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    gap_pct       = 34;
    eff_total     = MAX_PAGES_C;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // reset map is all used
    issue(REQ_ALLOC, 12'd0);
    issue(REQ_FREE, 12'd0);
    issue(REQ_FREE, 12'd0);
    issue(REQ_FREE, 12'd4095);
    issue(REQ_ALLOC, 12'd4095);
    issue(REQ_ALLOC, 12'd0);     // walks all 128 words to the last page
    issue(REQ_ALLOC, 12'd0);
    issue(REQ_RESERVE, 12'd5);
    issue(REQ_FREE, 12'd5);
    issue(REQ_RESERVE, 12'd5);
    issue(REQ_BAD, 12'd4095);
    issue(REQ_BAD, 12'd0);
    // partial tail word: reachable by free/reserve, never granted
    write_total(13'd100);
    issue(REQ_FREE, 12'd99);
    issue(REQ_FREE, 12'd100);
    issue(REQ_RESERVE, 12'd4095);
    issue(REQ_ALLOC, 12'd0);
    issue(REQ_FREE, 12'd95);
    issue(REQ_ALLOC, 12'd0);
    issue(REQ_RESERVE, 12'd99);
    write_total(13'd0);
    issue(REQ_ALLOC, 12'd0);
    issue(REQ_FREE, 12'd0);
    write_total(13'h1FFF);       // saturates to the maximum
    issue(REQ_FREE, 12'd4095);
    issue(REQ_ALLOC, 12'd0);

    for (int mode = 0; mode < 3; mode++) begin
      gap_pct = (mode == 0) ? 34 : (mode == 1) ? 54 : 0;
      for (int p = 0; p < 5; p++) begin
        if (mode == 0) begin
          v = fixed_totals[p];
        end else begin
          case ($urandom_range(0, 7))
            0:       v = MAX_PAGES_C;
            1:       v = 13'h1FFF;
            2:       v = 13'd0;
            3:       v = 13'd32;
            4:       v = CNT_W'($urandom_range(33, 300));
            5:       v = CNT_W'($urandom_range(0, 8191));
            6:       v = 13'd31;
            default: v = CNT_W'($urandom_range(1, 4095));
          endcase
        end
        write_total(v);
        repeat (104) random_item();
      end
    end

    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("bitmap_page_allocator: match");
    else
      $display("bitmap_page_allocator: mismatch");
    $finish;
  end

endmodule
